### sv/kpac_pkg.sv
package kpac_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_TICK = 2'd1,
    OP_POT  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_PIN_CODE   = 1'b0,
    CFG_TIMEOUT_MS = 1'b1
  } cfg_index_t;

  // Key codes
  localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  localparam logic [2:0]  PIN_DIGITS     = 3'd4;
  localparam logic [9:0]  MS_PER_SECOND  = 10'd1000;
  localparam logic [10:0] POT_FULL       = 11'd1023;
  localparam logic [6:0]  POT_SPAN       = 7'd99;

  localparam logic [15:0] PIN_CODE_RESET   = 16'h1234;
  localparam logic [15:0] TIMEOUT_MS_RESET = 16'd5000;

  // x/10 for x below 180 is (x*205)>>11
  localparam logic [7:0] DIV10_MUL = 8'd205;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  key_code;
    logic [9:0]  pot_raw;
  } kpac_cmd_t;

  typedef struct packed {
    logic [2:0]  pin_length;
    logic        counting_down;
    logic [6:0]  seconds_left;
    logic        wrong_pin;
    logic        armed;
    logic [6:0]  delay_setting;
    logic [3:0]  display_tens;
    logic [3:0]  display_units;
  } kpac_res_t;

  typedef struct packed {
    logic [15:0] pin_code;
    logic [15:0] idle_limit_ms;
  } kpac_cfg_t;

endpackage

### sv/kpac_cfg_regs.sv
module kpac_cfg_regs import kpac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_data,
  output kpac_cfg_t   cfg
);

  // Register file; the user must write it only while the block is idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_code      <= PIN_CODE_RESET;
      cfg.idle_limit_ms <= TIMEOUT_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIN_CODE:   cfg.pin_code      <= cfg_data;
        CFG_TIMEOUT_MS: cfg.idle_limit_ms <= cfg_data;
      endcase
    end
  end

endmodule

### sv/kpac_engine.sv
module kpac_engine import kpac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  kpac_cmd_t cmd,
  input  kpac_cfg_t cfg,
  output kpac_res_t res
);

  logic [15:0] entered_digits, entered_digits_next;
  logic [2:0]  entered_count, entered_count_next;
  logic [15:0] idle_ms, idle_ms_next;
  logic        countdown_active, countdown_active_next;
  logic [6:0]  countdown_seconds, countdown_seconds_next;
  logic [9:0]  ms_into_second, ms_into_second_next;
  logic [6:0]  delay_value, delay_value_next;

  // Pot mapping: raw*99/1023 via >>10 plus one correction
  logic [16:0] pot_prod;
  logic [6:0]  pot_q0;
  logic [10:0] pot_rem;
  logic [6:0]  pot_mapped;

  assign pot_prod   = 17'(cmd.pot_raw) * 17'(POT_SPAN);
  assign pot_q0     = pot_prod[16:10];
  assign pot_rem    = 11'(pot_prod[9:0]) + 11'(pot_q0);
  assign pot_mapped = (pot_rem >= POT_FULL) ? pot_q0 + 7'd1 : pot_q0;

  // State update for one request
  logic        wrong, armed;
  logic [15:0] shifted;
  logic [2:0]  count_inc;
  logic [9:0]  ms_inc;
  logic [6:0]  sec_dec;

  always_comb begin
    entered_digits_next    = entered_digits;
    entered_count_next     = entered_count;
    idle_ms_next           = idle_ms;
    countdown_active_next  = countdown_active;
    countdown_seconds_next = countdown_seconds;
    ms_into_second_next    = ms_into_second;
    delay_value_next       = delay_value;
    wrong                  = 1'b0;
    armed                  = 1'b0;
    shifted   = {entered_digits[11:0], cmd.key_code};
    count_inc = entered_count + 3'd1;
    ms_inc    = ms_into_second + 10'd1;
    sec_dec   = (countdown_seconds != 7'd0) ? countdown_seconds - 7'd1 : 7'd0;

    unique case (cmd.opcode)
      OP_KEY: begin
        priority if (cmd.key_code <= KEY_MAX_DIGIT) begin
          if (entered_count >= PIN_DIGITS) begin
            // a fifth digit never matches
            entered_digits_next = '0;
            entered_count_next  = '0;
            idle_ms_next        = '0;
            wrong               = 1'b1;
          end else if (count_inc == PIN_DIGITS && shifted != cfg.pin_code) begin
            entered_digits_next = '0;
            entered_count_next  = '0;
            idle_ms_next        = '0;
            wrong               = 1'b1;
          end else begin
            entered_digits_next = shifted;
            entered_count_next  = count_inc;
            idle_ms_next        = '0;
            if (count_inc == PIN_DIGITS) begin
              countdown_seconds_next = delay_value;
              countdown_active_next  = 1'b1;
              ms_into_second_next    = '0;
            end
          end
        end else if (cmd.key_code == KEY_STAR) begin
          if (entered_count == PIN_DIGITS && entered_digits == cfg.pin_code) begin
            countdown_seconds_next = delay_value;
            countdown_active_next  = 1'b1;
            ms_into_second_next    = '0;
          end else begin
            entered_digits_next = '0;
            entered_count_next  = '0;
            idle_ms_next        = '0;
            wrong               = 1'b1;
          end
        end else if (cmd.key_code == KEY_HASH) begin
          // hash leaves the idle time alone
          entered_digits_next = '0;
          entered_count_next  = '0;
        end else begin
          // unused keys
        end
      end
      OP_TICK: begin
        if (entered_count != 3'd0) begin
          if (idle_ms >= cfg.idle_limit_ms) begin
            entered_digits_next = '0;
            entered_count_next  = '0;
            idle_ms_next        = '0;
          end else begin
            idle_ms_next = idle_ms + 16'd1;
          end
        end
        if (countdown_active) begin
          if (ms_inc >= MS_PER_SECOND) begin
            ms_into_second_next    = '0;
            countdown_seconds_next = sec_dec;
            if (sec_dec == 7'd0) begin
              countdown_active_next = 1'b0;
              armed                 = 1'b1;
            end
          end else begin
            ms_into_second_next = ms_inc;
          end
        end
      end
      OP_POT:  delay_value_next = pot_mapped;
      OP_NONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entered_digits    <= '0;
      entered_count     <= '0;
      idle_ms           <= '0;
      countdown_active  <= 1'b0;
      countdown_seconds <= '0;
      ms_into_second    <= '0;
      delay_value       <= '0;
    end else if (step) begin
      entered_digits    <= entered_digits_next;
      entered_count     <= entered_count_next;
      idle_ms           <= idle_ms_next;
      countdown_active  <= countdown_active_next;
      countdown_seconds <= countdown_seconds_next;
      ms_into_second    <= ms_into_second_next;
      delay_value       <= delay_value_next;
    end
  end

  // Display value split into BCD digits
  logic [6:0]  shown;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  units_wide;

  assign shown      = countdown_active_next ? countdown_seconds_next : delay_value_next;
  assign tens_prod  = 15'(shown) * 15'(DIV10_MUL);
  assign tens       = tens_prod[14:11];
  assign units_wide = shown - 7'(tens) * 7'd10;

  always_comb begin
    res.pin_length    = entered_count_next;
    res.counting_down = countdown_active_next;
    res.seconds_left  = countdown_seconds_next;
    res.wrong_pin     = wrong;
    res.armed         = armed;
    res.delay_setting = delay_value_next;
    res.display_tens  = tens;
    res.display_units = units_wide[3:0];
  end

endmodule

### sv/keypad_pin_arming_controller.sv
// Keypad PIN arming controller.
// A request passes the input register, then the result register; res_valid rises when the result register loads.
// Throughput: one request per cycle while res_ready is high; the single-pass state update sets this figure.
// Reset (synchronous, active high): PIN, timers and countdown cleared, delay 0,
// PIN code 0x1234, timeout 5000 ms, both pipeline registers empty.
module keypad_pin_arming_controller import kpac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  kpac_cmd_t   cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output kpac_res_t   res,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_data
);

  kpac_cfg_t cfg;
  kpac_cmd_t cmd_q;
  logic      cmd_q_valid;
  logic      advance;
  kpac_res_t res_next;

  kpac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Request moves into the result register when that slot is free or is being read out
  assign advance   = cmd_q_valid && (!res_valid || res_ready);
  assign cmd_ready = !cmd_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_ready) begin
      cmd_q_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

  kpac_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd_q),
    .cfg  (cfg),
    .res  (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
